/* rtl/rpfc_pkg.sv */
`default_nettype none
package rpfc_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 9;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_GRAYSCALE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INVERT    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PASTEL    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HUE_STEP  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CRT       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DARKEN    = 3'd5;

  localparam logic [8:0]  DARKEN_RESET  = 9'd128;
  localparam logic [8:0]  HUE_FULL      = 9'd360;
  localparam logic [5:0]  SECTOR_DEG    = 6'd60;
  localparam logic [15:0] LUM_WR        = 16'd13933;
  localparam logic [15:0] LUM_WG        = 16'd46871;
  localparam logic [15:0] LUM_WB        = 16'd4732;
  localparam logic [7:0]  PASTEL_MUL    = 8'd154;
  // floor(p/60) = (p*RECIP60) >> 20, exact for p below 23831
  localparam logic [14:0] RECIP60       = 15'd17477;

  // c*255/31 for every 5-bit code
  localparam logic [7:0] WIDEN_LUT [32] = '{
    8'd0,   8'd8,   8'd16,  8'd24,  8'd32,  8'd41,  8'd49,  8'd57,
    8'd65,  8'd74,  8'd82,  8'd90,  8'd98,  8'd106, 8'd115, 8'd123,
    8'd131, 8'd139, 8'd148, 8'd156, 8'd164, 8'd172, 8'd180, 8'd189,
    8'd197, 8'd205, 8'd213, 8'd222, 8'd230, 8'd238, 8'd246, 8'd255
  };

  typedef struct packed {
    logic              vld;
    logic [7:0]        r;
    logic [7:0]        g;
    logic [7:0]        b;
    logic [8:0]        line;
    logic signed [7:0] noise;
    logic [8:0]        angle;
  } pix_t;

  typedef struct packed {
    logic       gray_on;
    logic       inv_on;
    logic       pastel_on;
    logic [8:0] hue_step;
    logic       crt_on;
    logic [8:0] darken;
  } cfg_t;

  typedef struct packed {
    logic [7:0] rem;
    logic       qbit;
  } div_step_t;

  // one restoring division step; rem stays below dvsr
  function automatic div_step_t div_step(input logic [7:0] rem, input logic nbit,
                                         input logic [7:0] dvsr);
    logic [8:0] t;
    div_step_t  res;
    t = {rem, nbit};
    if (t >= {1'b0, dvsr}) begin
      res.rem  = 8'(t - {1'b0, dvsr});
      res.qbit = 1'b1;
    end else begin
      res.rem  = t[7:0];
      res.qbit = 1'b0;
    end
    return res;
  endfunction

endpackage
`default_nettype wire

/* rtl/rpfc_in_if.sv */
`default_nettype none
interface rpfc_in_if;
  logic              valid;
  logic              ready;
  logic [15:0]       pixel_word;
  logic [8:0]        line_number;
  logic signed [7:0] noise;
  logic              frame_end;

  modport source(output valid, pixel_word, line_number, noise, frame_end, input ready);
  modport sink(input valid, pixel_word, line_number, noise, frame_end, output ready);
endinterface
`default_nettype wire

/* rtl/rpfc_out_if.sv */
`default_nettype none
interface rpfc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] red_out;
  logic [7:0] green_out;
  logic [7:0] blue_out;

  modport source(output valid, red_out, green_out, blue_out, input ready);
  modport sink(input valid, red_out, green_out, blue_out, output ready);
endinterface
`default_nettype wire

/* rtl/rpfc_cfg_if.sv */
`default_nettype none
interface rpfc_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [rpfc_pkg::CFG_IDX_W-1:0]     index;
  logic [rpfc_pkg::CFG_DATA_W-1:0]    data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface
`default_nettype wire

/* rtl/rpfc_front.sv */
`default_nettype none
module rpfc_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              adv,
  input  logic              in_vld,
  input  logic [15:0]       pixel_word,
  input  logic [8:0]        line_number,
  input  logic signed [7:0] noise,
  input  logic [8:0]        angle,
  input  rpfc_pkg::cfg_t    cfg,
  output rpfc_pkg::pix_t    pix_out
);

  rpfc_pkg::pix_t f1_r, f1_nxt;
  rpfc_pkg::pix_t f2_r;
  rpfc_pkg::pix_t f3_r, f3_nxt;
  logic [23:0]    pr_r, pg_r, pb_r;
  logic [23:0]    pr_nxt, pg_nxt, pb_nxt;
  logic [23:0]    lum_sum;
  logic [7:0]     lum;

  // widen each channel
  always_comb begin
    f1_nxt.vld   = in_vld;
    f1_nxt.r     = rpfc_pkg::WIDEN_LUT[pixel_word[14:10]];
    f1_nxt.g     = rpfc_pkg::WIDEN_LUT[pixel_word[9:5]];
    f1_nxt.b     = rpfc_pkg::WIDEN_LUT[pixel_word[4:0]];
    f1_nxt.line  = line_number;
    f1_nxt.noise = noise;
    f1_nxt.angle = angle;
  end

  // luminance products
  assign pr_nxt = {8'b0, rpfc_pkg::LUM_WR} * {16'b0, f1_r.r};
  assign pg_nxt = {8'b0, rpfc_pkg::LUM_WG} * {16'b0, f1_r.g};
  assign pb_nxt = {8'b0, rpfc_pkg::LUM_WB} * {16'b0, f1_r.b};

  // sum, grayscale select, invert
  assign lum_sum = pr_r + pg_r + pb_r;
  assign lum     = lum_sum[23:16];

  always_comb begin
    f3_nxt = f2_r;
    if (cfg.gray_on) begin
      f3_nxt.r = lum;
      f3_nxt.g = lum;
      f3_nxt.b = lum;
    end
    if (cfg.inv_on) begin
      f3_nxt.r = ~f3_nxt.r;
      f3_nxt.g = ~f3_nxt.g;
      f3_nxt.b = ~f3_nxt.b;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_r.vld <= 1'b0;
      f2_r.vld <= 1'b0;
      f3_r.vld <= 1'b0;
    end else if (adv) begin
      f1_r <= f1_nxt;
      f2_r <= f1_r;
      f3_r <= f3_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pr_r <= pr_nxt;
      pg_r <= pg_nxt;
      pb_r <= pb_nxt;
    end
  end

  assign pix_out = f3_r;

endmodule
`default_nettype wire

/* rtl/rpfc_hsv.sv */
`default_nettype none
module rpfc_hsv (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           adv,
  input  logic           en,
  input  logic           pastel_mode,
  input  rpfc_pkg::pix_t pix_in,
  output rpfc_pkg::pix_t pix_out
);

  localparam int DIV_STEPS = 9;
  localparam int P1_IDX    = DIV_STEPS;
  localparam int STAGES    = DIV_STEPS + 6;

  localparam logic [1:0] BASE_RED   = 2'd0;
  localparam logic [1:0] BASE_GREEN = 2'd1;
  localparam logic [1:0] BASE_BLUE  = 2'd2;

  typedef struct packed {
    logic [7:0] mx;
    logic [7:0] d;
    logic [7:0] a;
    logic       neg;
    logic [1:0] base;
    logic       zero;
  } hsv0_t;

  typedef struct packed {
    logic [15:0] ns;
    logic [15:0] nh;
    logic [7:0]  rs;
    logic [7:0]  rh;
    logic [8:0]  qs;
    logic [8:0]  qh;
    logic [7:0]  mx;
    logic [7:0]  d;
    logic        neg;
    logic [1:0]  base;
    logic        zero;
  } quo_t;

  typedef struct packed {
    logic [8:0] h;
    logic [8:0] s;
    logic [7:0] v;
  } p1_t;

  typedef struct packed {
    logic [7:0] c;
    logic [7:0] v;
    logic [2:0] sector;
    logic [5:0] f;
  } p2_t;

  typedef struct packed {
    logic [13:0] p;
    logic [7:0]  c;
    logic [7:0]  m;
    logic [2:0]  sector;
  } p3_t;

  typedef struct packed {
    logic [7:0] x;
    logic [7:0] c;
    logic [7:0] m;
    logic [2:0] sector;
  } p4_t;

  rpfc_pkg::pix_t pix_r   [STAGES];
  rpfc_pkg::pix_t pix_nxt [STAGES];
  hsv0_t          hsv0_r, hsv0_nxt;
  quo_t           div_r   [DIV_STEPS];
  quo_t           div_nxt [DIV_STEPS];
  p1_t            p1_r, p1_nxt;
  p2_t            p2_r, p2_nxt;
  p3_t            p3_r, p3_nxt;
  p4_t            p4_r, p4_nxt;

  logic [7:0]  s0_mx, s0_mn;
  logic [8:0]  s9, hdeg, base_deg, h_rot;
  logic [9:0]  rot_sum;
  logic [16:0] sat_prod, c_prod;
  logic [8:0]  secdeg;
  logic [5:0]  fm;
  logic [28:0] x_prod;
  logic [7:0]  cm, xm;

  // max, min and the numerator of the hue term
  always_comb begin
    s0_mx = pix_in.r;
    if (pix_in.g > s0_mx) s0_mx = pix_in.g;
    if (pix_in.b > s0_mx) s0_mx = pix_in.b;
    s0_mn = pix_in.r;
    if (pix_in.g < s0_mn) s0_mn = pix_in.g;
    if (pix_in.b < s0_mn) s0_mn = pix_in.b;
    hsv0_nxt.mx   = s0_mx;
    hsv0_nxt.d    = s0_mx - s0_mn;
    hsv0_nxt.zero = (s0_mx == s0_mn);
    if (pix_in.r == s0_mx) begin
      hsv0_nxt.base = BASE_RED;
      hsv0_nxt.neg  = pix_in.g < pix_in.b;
      hsv0_nxt.a    = hsv0_nxt.neg ? pix_in.b - pix_in.g : pix_in.g - pix_in.b;
    end else if (pix_in.g == s0_mx) begin
      hsv0_nxt.base = BASE_GREEN;
      hsv0_nxt.neg  = pix_in.b < pix_in.r;
      hsv0_nxt.a    = hsv0_nxt.neg ? pix_in.r - pix_in.b : pix_in.b - pix_in.r;
    end else begin
      hsv0_nxt.base = BASE_BLUE;
      hsv0_nxt.neg  = pix_in.r < pix_in.g;
      hsv0_nxt.a    = hsv0_nxt.neg ? pix_in.g - pix_in.r : pix_in.r - pix_in.g;
    end
  end

  // two dividers side by side, one quotient bit per stage:
  // saturation d*256/max and hue term 60*a/d
  always_comb begin
    quo_t             src;
    rpfc_pkg::div_step_t st_s, st_h;
    src.ns   = {hsv0_r.d, 8'h00};
    src.nh   = {2'b00, hsv0_r.a, 6'b0} - {6'b0, hsv0_r.a, 2'b0};
    src.rs   = {1'b0, src.ns[15:9]};
    src.rh   = {1'b0, src.nh[15:9]};
    src.qs   = '0;
    src.qh   = '0;
    src.mx   = hsv0_r.mx;
    src.d    = hsv0_r.d;
    src.neg  = hsv0_r.neg;
    src.base = hsv0_r.base;
    src.zero = hsv0_r.zero;
    for (int k = 0; k < DIV_STEPS; k++) begin
      if (k > 0) src = div_r[k-1];
      st_s = rpfc_pkg::div_step(src.rs, src.ns[DIV_STEPS-1-k], src.mx);
      st_h = rpfc_pkg::div_step(src.rh, src.nh[DIV_STEPS-1-k], src.d);
      div_nxt[k]    = src;
      div_nxt[k].rs = st_s.rem;
      div_nxt[k].rh = st_h.rem;
      div_nxt[k].qs = {src.qs[7:0], st_s.qbit};
      div_nxt[k].qh = {src.qh[7:0], st_h.qbit};
    end
  end

  // hue in degrees, then pastel cut or rotation
  always_comb begin
    s9 = div_r[DIV_STEPS-1].zero ? 9'd0 : div_r[DIV_STEPS-1].qs;
    case (div_r[DIV_STEPS-1].base)
      BASE_GREEN: base_deg = 9'd120;
      BASE_BLUE:  base_deg = 9'd240;
      default:    base_deg = 9'd0;
    endcase
    if (!div_r[DIV_STEPS-1].neg) begin
      hdeg = base_deg + div_r[DIV_STEPS-1].qh;
    end else if (base_deg >= div_r[DIV_STEPS-1].qh) begin
      hdeg = base_deg - div_r[DIV_STEPS-1].qh;
    end else begin
      hdeg = base_deg + rpfc_pkg::HUE_FULL - div_r[DIV_STEPS-1].qh;
    end
    if (div_r[DIV_STEPS-1].zero) hdeg = 9'd0;
    sat_prod = {8'b0, s9} * {9'b0, rpfc_pkg::PASTEL_MUL};
    rot_sum  = {1'b0, hdeg} + {1'b0, pix_r[P1_IDX].angle};
    if (rot_sum >= {1'b0, rpfc_pkg::HUE_FULL}) rot_sum = rot_sum - {1'b0, rpfc_pkg::HUE_FULL};
    h_rot    = rot_sum[8:0];
    p1_nxt.h = pastel_mode ? hdeg : h_rot;
    p1_nxt.s = pastel_mode ? sat_prod[16:8] : s9;
    p1_nxt.v = div_r[DIV_STEPS-1].mx;
  end

  // chroma and sector
  always_comb begin
    c_prod        = {9'b0, p1_r.v} * {8'b0, p1_r.s};
    p2_nxt.c      = c_prod[15:8];
    p2_nxt.v      = p1_r.v;
    p2_nxt.sector = 3'd0;
    secdeg        = 9'd0;
    for (int k = 1; k < 6; k++) begin
      if (p1_r.h >= 9'(k * rpfc_pkg::SECTOR_DEG)) begin
        p2_nxt.sector = 3'(k);
        secdeg        = 9'(k * rpfc_pkg::SECTOR_DEG);
      end
    end
    p2_nxt.f = 6'(p1_r.h - secdeg);
  end

  // ramp product
  always_comb begin
    fm            = p2_r.sector[0] ? rpfc_pkg::SECTOR_DEG - p2_r.f : p2_r.f;
    p3_nxt.p      = {6'b0, p2_r.c} * {8'b0, fm};
    p3_nxt.c      = p2_r.c;
    p3_nxt.m      = p2_r.v - p2_r.c;
    p3_nxt.sector = p2_r.sector;
  end

  // divide the ramp by sixty
  always_comb begin
    x_prod        = {15'b0, p3_r.p} * {14'b0, rpfc_pkg::RECIP60};
    p4_nxt.x      = x_prod[27:20];
    p4_nxt.c      = p3_r.c;
    p4_nxt.m      = p3_r.m;
    p4_nxt.sector = p3_r.sector;
  end

  // carry the word along, rebuild rgb at the last stage
  always_comb begin
    cm         = p4_r.c + p4_r.m;
    xm         = p4_r.x + p4_r.m;
    pix_nxt[0] = pix_in;
    for (int k = 1; k < STAGES; k++) pix_nxt[k] = pix_r[k-1];
    if (en) begin
      case (p4_r.sector)
        3'd0: begin
          pix_nxt[STAGES-1].r = cm;  pix_nxt[STAGES-1].g = xm;  pix_nxt[STAGES-1].b = p4_r.m;
        end
        3'd1: begin
          pix_nxt[STAGES-1].r = xm;  pix_nxt[STAGES-1].g = cm;  pix_nxt[STAGES-1].b = p4_r.m;
        end
        3'd2: begin
          pix_nxt[STAGES-1].r = p4_r.m;  pix_nxt[STAGES-1].g = cm;  pix_nxt[STAGES-1].b = xm;
        end
        3'd3: begin
          pix_nxt[STAGES-1].r = p4_r.m;  pix_nxt[STAGES-1].g = xm;  pix_nxt[STAGES-1].b = cm;
        end
        3'd4: begin
          pix_nxt[STAGES-1].r = xm;  pix_nxt[STAGES-1].g = p4_r.m;  pix_nxt[STAGES-1].b = cm;
        end
        default: begin
          pix_nxt[STAGES-1].r = cm;  pix_nxt[STAGES-1].g = p4_r.m;  pix_nxt[STAGES-1].b = xm;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < STAGES; k++) pix_r[k].vld <= 1'b0;
    end else if (adv) begin
      for (int k = 0; k < STAGES; k++) pix_r[k] <= pix_nxt[k];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      hsv0_r <= hsv0_nxt;
      for (int k = 0; k < DIV_STEPS; k++) div_r[k] <= div_nxt[k];
      p1_r <= p1_nxt;
      p2_r <= p2_nxt;
      p3_r <= p3_nxt;
      p4_r <= p4_nxt;
    end
  end

  assign pix_out = pix_r[STAGES-1];

endmodule
`default_nettype wire

/* rtl/rpfc_crt.sv */
`default_nettype none
module rpfc_crt (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           adv,
  input  rpfc_pkg::cfg_t cfg,
  input  rpfc_pkg::pix_t pix_in,
  output rpfc_pkg::pix_t pix_out
);

  rpfc_pkg::pix_t c1_r;
  rpfc_pkg::pix_t c2_r, c2_nxt;
  logic [8:0]     rr_r, gg_r, bb_r;
  logic [8:0]     rr_nxt, gg_nxt, bb_nxt;
  logic [16:0]    pr, pg, pb;
  logic           dark;

  function automatic logic [7:0] clamp_add(input logic [8:0] c, input logic [7:0] n);
    logic [10:0] s;
    s = {2'b00, c} + {{3{n[7]}}, n};
    if (s[10]) return 8'd0;
    else if (s[9:8] != 2'b00) return 8'd255;
    else return s[7:0];
  endfunction

  // darken even lines
  assign dark   = cfg.crt_on && !pix_in.line[0];
  assign pr     = {9'b0, pix_in.r} * {8'b0, cfg.darken};
  assign pg     = {9'b0, pix_in.g} * {8'b0, cfg.darken};
  assign pb     = {9'b0, pix_in.b} * {8'b0, cfg.darken};
  assign rr_nxt = dark ? pr[16:8] : {1'b0, pix_in.r};
  assign gg_nxt = dark ? pg[16:8] : {1'b0, pix_in.g};
  assign bb_nxt = dark ? pb[16:8] : {1'b0, pix_in.b};

  // add noise and clamp
  always_comb begin
    c2_nxt = c1_r;
    if (cfg.crt_on) begin
      c2_nxt.r = clamp_add(rr_r, c1_r.noise);
      c2_nxt.g = clamp_add(gg_r, c1_r.noise);
      c2_nxt.b = clamp_add(bb_r, c1_r.noise);
    end else begin
      c2_nxt.r = rr_r[7:0];
      c2_nxt.g = gg_r[7:0];
      c2_nxt.b = bb_r[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c1_r.vld <= 1'b0;
      c2_r.vld <= 1'b0;
    end else if (adv) begin
      c1_r <= pix_in;
      c2_r <= c2_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rr_r <= rr_nxt;
      gg_r <= gg_nxt;
      bb_r <= bb_nxt;
    end
  end

  assign pix_out = c2_r;

endmodule
`default_nettype wire

/* rtl/rgb555_pixel_filter_chain_unit.sv */
`default_nettype none
// channel  | dir | handshake       | word
// ---------+-----+-----------------+-------------------------------------------
// in_ch    | in  | valid / ready   | pixel_word, line_number, noise, frame_end
// out_ch   | out | valid / ready   | red_out, green_out, blue_out
// cfg_ch   | in  | valid / ready   | index (0..5), data (9 bits); ready tied high
//
// One word enters per cycle while out_ch does not stall; each word passes 36 register
// stages, most of them in two HSV passes of 15 stages each: in each pass two 9-stage
// restoring dividers retire one quotient bit per stage.
// Synchronous active-low reset clears valid bits and hue angle and loads config defaults.
// A stall on out_ch freezes the whole pipe in place; in_ch.ready drops with it.
module rgb555_pixel_filter_chain_unit (
  input  logic       clk,
  input  logic       rst_n,
  rpfc_in_if.sink    in_ch,
  rpfc_out_if.source out_ch,
  rpfc_cfg_if.sink   cfg_ch
);

  rpfc_pkg::cfg_t cfg_r;
  logic [8:0]     hue_angle_r, hue_angle_nxt;
  logic [9:0]     angle_sum;
  logic           adv;
  logic           in_acc;
  logic           out_vld_r;
  logic [7:0]     red_r, green_r, blue_r;

  rpfc_pkg::pix_t front_pix, pastel_pix, hue_pix, crt_pix;

  // advance whenever the output register is empty or being drained
  assign adv          = !out_vld_r || out_ch.ready;
  assign in_ch.ready  = adv;
  assign in_acc       = in_ch.valid && adv;
  assign cfg_ch.ready = 1'b1;

  // configuration writes; unknown indexes drop
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gray_on   <= 1'b0;
      cfg_r.inv_on    <= 1'b0;
      cfg_r.pastel_on <= 1'b0;
      cfg_r.hue_step  <= 9'd0;
      cfg_r.crt_on    <= 1'b0;
      cfg_r.darken    <= rpfc_pkg::DARKEN_RESET;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        rpfc_pkg::REG_GRAYSCALE: cfg_r.gray_on   <= cfg_ch.data[0];
        rpfc_pkg::REG_INVERT:    cfg_r.inv_on    <= cfg_ch.data[0];
        rpfc_pkg::REG_PASTEL:    cfg_r.pastel_on <= cfg_ch.data[0];
        rpfc_pkg::REG_HUE_STEP:  cfg_r.hue_step  <= cfg_ch.data;
        rpfc_pkg::REG_CRT:       cfg_r.crt_on    <= cfg_ch.data[0];
        rpfc_pkg::REG_DARKEN:    cfg_r.darken    <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  // hue angle: each word carries the angle seen at acceptance; frame end
  // then advances it modulo 360 (sum stays below 720 + 360)
  always_comb begin
    angle_sum = {1'b0, hue_angle_r} + {1'b0, cfg_r.hue_step};
    if (angle_sum >= {rpfc_pkg::HUE_FULL, 1'b0}) begin
      angle_sum = angle_sum - {rpfc_pkg::HUE_FULL, 1'b0};
    end else if (angle_sum >= {1'b0, rpfc_pkg::HUE_FULL}) begin
      angle_sum = angle_sum - {1'b0, rpfc_pkg::HUE_FULL};
    end
    hue_angle_nxt = (in_acc && in_ch.frame_end) ? angle_sum[8:0] : hue_angle_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hue_angle_r <= 9'd0;
    end else begin
      hue_angle_r <= hue_angle_nxt;
    end
  end

  // widen, grayscale, invert
  rpfc_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .adv         (adv),
    .in_vld      (in_ch.valid),
    .pixel_word  (in_ch.pixel_word),
    .line_number (in_ch.line_number),
    .noise       (in_ch.noise),
    .angle       (hue_angle_r),
    .cfg         (cfg_r),
    .pix_out     (front_pix)
  );

  // pastel: saturation cut, hue kept
  rpfc_hsv u_pastel (
    .clk         (clk),
    .rst_n       (rst_n),
    .adv         (adv),
    .en          (cfg_r.pastel_on),
    .pastel_mode (1'b1),
    .pix_in      (front_pix),
    .pix_out     (pastel_pix)
  );

  // hue rotation by the carried angle
  rpfc_hsv u_hue (
    .clk         (clk),
    .rst_n       (rst_n),
    .adv         (adv),
    .en          (|cfg_r.hue_step),
    .pastel_mode (1'b0),
    .pix_in      (pastel_pix),
    .pix_out     (hue_pix)
  );

  // scanline darkening and noise
  rpfc_crt u_crt (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .cfg     (cfg_r),
    .pix_in  (hue_pix),
    .pix_out (crt_pix)
  );

  // output register: hold while the sink stalls
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= crt_pix.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      red_r   <= crt_pix.r;
      green_r <= crt_pix.g;
      blue_r  <= crt_pix.b;
    end
  end

  assign out_ch.valid     = out_vld_r;
  assign out_ch.red_out   = red_r;
  assign out_ch.green_out = green_r;
  assign out_ch.blue_out  = blue_r;

endmodule
`default_nettype wire

/* test/rgb555_pixel_filter_chain_unit_test_if.sv */
`timescale 1ns / 100ps
// Shared handshake helpers are local to the top; this file only anchors the
// interface instances' clock generator for the testbench build.
module rgb555_pixel_filter_chain_unit_test_clkgen (
  output logic clk
);
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end
endmodule

/* test/rgb555_pixel_filter_chain_unit_test.sv */
`timescale 1ns / 100ps
module rgb555_pixel_filter_chain_unit_test;

  // Drain margin after the last expected pixel.
  localparam int DRAIN_CYCLES = 80;
  localparam int CYCLE_LIMIT  = 200000;

  typedef struct {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  logic clk;
  logic rst_n;

  rpfc_in_if  pix_ch ();
  rpfc_out_if rgb_ch ();
  rpfc_cfg_if reg_ch ();

  rgb555_pixel_filter_chain_unit u_top (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (pix_ch.sink),
    .out_ch(rgb_ch.source),
    .cfg_ch(reg_ch.sink)
  );

  rgb555_pixel_filter_chain_unit_test_clkgen u_clk (.clk(clk));

  // Shadow copy of the register file and the hue angle.
  logic       gray_en, inv_en, pastel_en, crt_en;
  logic [8:0] hue_step, darken, hue_angle;

  rgb_t pixel_queue[$];
  int   fail_count;
  int   cycle_count;
  bit   stall_free;   // when set, neither side idles

  // ---------------------------------------------------------------------------
  // Color-space helpers: integer HSV with truncation toward zero.
  // ---------------------------------------------------------------------------
  task automatic rgb_to_hsv(input int r, g, b, output int h, s, v);
    int mx, mn, d, t;
    mx = r; mn = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    v = mx;
    d = mx - mn;
    if (d == 0) begin
      s = 0;
      h = 0;
    end else begin
      s = (d * 256) / mx;
      if (r == mx) t = (60 * (g - b)) / d;
      else if (g == mx) t = 120 + (60 * (b - r)) / d;
      else t = 240 + (60 * (r - g)) / d;
      if (t < 0) t += 360;
      h = t % 360;
    end
  endtask

  task automatic hsv_to_rgb(input int h, s, v, output int r, g, b);
    int c, m, sec, f, x;
    c = (v * s) >> 8;
    m = v - c;
    sec = (h / 60) % 6;
    f = h % 60;
    x = (sec & 1) ? (c * (60 - f)) / 60 : (c * f) / 60;
    case (sec)
      0: begin r = c + m; g = x + m; b = m; end
      1: begin r = x + m; g = c + m; b = m; end
      2: begin r = m; g = c + m; b = x + m; end
      3: begin r = m; g = x + m; b = c + m; end
      4: begin r = x + m; g = m; b = c + m; end
      default: begin r = c + m; g = m; b = x + m; end
    endcase
  endtask

  function automatic int clamp_byte(input int x);
    if (x < 0) return 0;
    if (x > 255) return 255;
    return x;
  endfunction

  // Compute the filtered pixel for one word, then advance the hue angle on
  // a frame end.
  task automatic filter_pixel(input logic [15:0] px, input logic [8:0] line,
                              input logic signed [7:0] noise, input logic fend);
    int   r, g, b, h, s, v, lum;
    rgb_t res;
    r = (int'(px[14:10]) * 255) / 31;
    g = (int'(px[9:5]) * 255) / 31;
    b = (int'(px[4:0]) * 255) / 31;
    if (gray_en) begin
      lum = (13933 * r + 46871 * g + 4732 * b) >>> 16;
      r = lum; g = lum; b = lum;
    end
    if (inv_en) begin
      r = 255 - r; g = 255 - g; b = 255 - b;
    end
    if (pastel_en) begin
      rgb_to_hsv(r, g, b, h, s, v);
      s = (s * 154) >> 8;
      hsv_to_rgb(h, s, v, r, g, b);
    end
    if (hue_step != 0) begin
      rgb_to_hsv(r, g, b, h, s, v);
      h = (h + int'(hue_angle)) % 360;
      hsv_to_rgb(h, s, v, r, g, b);
    end
    if (crt_en) begin
      if (!line[0]) begin
        r = (r * int'(darken)) >> 8;
        g = (g * int'(darken)) >> 8;
        b = (b * int'(darken)) >> 8;
      end
      r = clamp_byte(r + int'(noise));
      g = clamp_byte(g + int'(noise));
      b = clamp_byte(b + int'(noise));
    end
    res.red = r[7:0]; res.green = g[7:0]; res.blue = b[7:0];
    pixel_queue.push_back(res);
    if (fend) hue_angle = 9'((int'(hue_angle) + int'(hue_step)) % 360);
  endtask

  // ---------------------------------------------------------------------------
  // Clock counter and timeout.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Drive sink ready: drop it at random, with chance 8/100, unless in a stall-free stretch.
  always @(posedge clk) begin
    if (!rst_n) rgb_ch.ready <= 1'b0;
    else rgb_ch.ready <= stall_free || ($urandom_range(99) >= 8);
  end

  // Check each accepted word against the oldest expected pixel.
  always @(posedge clk) begin
    rgb_t want;
    if (rst_n && rgb_ch.valid && rgb_ch.ready) begin
      if (pixel_queue.size() == 0) begin
        $error("unexpected word r=%0d g=%0d b=%0d", rgb_ch.red_out, rgb_ch.green_out,
               rgb_ch.blue_out);
        fail_count++;
      end else begin
        want = pixel_queue.pop_front();
        if (rgb_ch.red_out !== want.red) begin
          $error("red_out expected %0d actual %0d", want.red, rgb_ch.red_out);
          fail_count++;
        end
        if (rgb_ch.green_out !== want.green) begin
          $error("green_out expected %0d actual %0d", want.green, rgb_ch.green_out);
          fail_count++;
        end
        if (rgb_ch.blue_out !== want.blue) begin
          $error("blue_out expected %0d actual %0d", want.blue, rgb_ch.blue_out);
          fail_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Drivers.
  // ---------------------------------------------------------------------------
  // Send one pixel word; hold valid until accepted, idle beforehand at random.
  task automatic send_pixel(input logic [15:0] px, input logic [8:0] line,
                            input logic signed [7:0] noise, input logic fend);
    while (!stall_free && $urandom_range(99) < 8) begin
      pix_ch.valid <= 1'b0;
      @(posedge clk);
    end
    pix_ch.valid       <= 1'b1;
    pix_ch.pixel_word  <= px;
    pix_ch.line_number <= line;
    pix_ch.noise       <= noise;
    pix_ch.frame_end   <= fend;
    @(posedge clk);
    while (!pix_ch.ready) @(posedge clk);
    filter_pixel(px, line, noise, fend);
  endtask

  task automatic release_input();
    pix_ch.valid <= 1'b0;
  endtask

  // Wait for every expected pixel, then let the pipe drain.
  task automatic drain_pipe();
    release_input();
    @(posedge clk);
    while (pixel_queue.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Hold valid through back-to-back writes; the caller drops it afterwards.
  task automatic write_reg(input logic [rpfc_pkg::CFG_IDX_W-1:0] idx,
                           input logic [8:0] val);
    reg_ch.valid <= 1'b1;
    reg_ch.index <= idx;
    reg_ch.data  <= val;
    @(posedge clk);
    while (!reg_ch.ready) @(posedge clk);
    case (idx)
      rpfc_pkg::REG_GRAYSCALE: gray_en   = val[0];
      rpfc_pkg::REG_INVERT:    inv_en    = val[0];
      rpfc_pkg::REG_PASTEL:    pastel_en = val[0];
      rpfc_pkg::REG_HUE_STEP:  hue_step  = val;
      rpfc_pkg::REG_CRT:       crt_en    = val[0];
      rpfc_pkg::REG_DARKEN:    darken    = val;
      default: ;
    endcase
  endtask

  task automatic set_chain(input logic g, i, p, input logic [8:0] hs,
                           input logic c, input logic [8:0] dk);
    write_reg(rpfc_pkg::REG_GRAYSCALE, {8'd0, g});
    write_reg(rpfc_pkg::REG_INVERT, {8'd0, i});
    write_reg(rpfc_pkg::REG_PASTEL, {8'd0, p});
    write_reg(rpfc_pkg::REG_HUE_STEP, hs);
    write_reg(rpfc_pkg::REG_CRT, {8'd0, c});
    write_reg(rpfc_pkg::REG_DARKEN, dk);
    reg_ch.valid <= 1'b0;
  endtask

  function automatic logic [15:0] rand_pixel();
    return 16'($urandom);
  endfunction

  // ---------------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------------
  // Reset defaults: plain widening, field extremes, gray pixels.
  task automatic test_widening();
    send_pixel(16'h0000, 9'd0, 8'sd0, 1'b0);
    send_pixel(16'hFFFF, 9'd511, -8'sd128, 1'b1);
    send_pixel(16'h7FFF, 9'd1, 8'sd127, 1'b0);
    send_pixel(16'h7C00, 9'd2, 8'sd0, 1'b0);
    send_pixel(16'h03E0, 9'd3, 8'sd0, 1'b0);
    send_pixel(16'h001F, 9'd4, 8'sd0, 1'b0);
    send_pixel(16'h5294, 9'd5, 8'sd0, 1'b0);  // gray pixel
    drain_pipe();
  endtask

  // Grayscale alone, invert with pastel, hue alone, CRT alone, then everything at once.
  task automatic test_stages();
    set_chain(1'b1, 1'b0, 1'b0, 9'd0, 1'b0, rpfc_pkg::DARKEN_RESET);
    send_pixel(16'h7C1F, 9'd0, 8'sd0, 1'b0);
    send_pixel(16'h2A55, 9'd0, 8'sd0, 1'b0);
    drain_pipe();
    set_chain(1'b0, 1'b1, 1'b1, 9'd0, 1'b0, rpfc_pkg::DARKEN_RESET);
    send_pixel(16'h7C00, 9'd0, 8'sd0, 1'b0);
    send_pixel(16'h1234, 9'd0, 8'sd0, 1'b0);
    send_pixel(16'h4210, 9'd0, 8'sd0, 1'b0);  // gray pixel through pastel
    drain_pipe();
    // Frame end advances the angle; two frame ends roll it past 360.
    set_chain(1'b0, 1'b0, 1'b0, 9'd359, 1'b0, rpfc_pkg::DARKEN_RESET);
    send_pixel(16'h7C00, 9'd0, 8'sd0, 1'b1);
    send_pixel(16'h03E0, 9'd0, 8'sd0, 1'b1);
    send_pixel(16'h6318, 9'd0, 8'sd0, 1'b0);
    drain_pipe();
    // Darken factor above 256 brightens; the clamp keeps the noise add in range.
    set_chain(1'b0, 1'b0, 1'b0, 9'd0, 1'b1, 9'd511);
    send_pixel(16'h7FFF, 9'd0, 8'sd127, 1'b0);
    send_pixel(16'h0000, 9'd2, -8'sd128, 1'b0);
    send_pixel(16'h3DEF, 9'd1, 8'sd5, 1'b0);
    drain_pipe();
    set_chain(1'b1, 1'b1, 1'b1, 9'd1, 1'b1, 9'd0);
    send_pixel(16'h56B5, 9'd0, 8'sd10, 1'b1);
    send_pixel(16'h56B5, 9'd0, -8'sd10, 1'b0);
    drain_pipe();
    // Hue stage disabled with a frame end: the angle still moves by zero.
    set_chain(1'b0, 1'b0, 1'b0, 9'd0, 1'b0, 9'd256);
    send_pixel(16'h1111, 9'd7, 8'sd0, 1'b1);
    drain_pipe();
  endtask

  // Random settings per phase; frames of random pixels with frame ends.
  task automatic test_random_frames();
    for (int phase = 0; phase < 12; phase++) begin
      set_chain(1'($urandom_range(1)), 1'($urandom_range(1)), 1'($urandom_range(1)),
                ($urandom_range(3) == 0) ? 9'd0 : 9'($urandom_range(359)),
                1'($urandom_range(1)),
                (phase == 0) ? 9'd0 : (phase == 1) ? 9'd511 : 9'($urandom_range(511)));
      stall_free = (phase == 5);
      for (int k = 0; k < 55; k++)
        send_pixel(rand_pixel(), 9'($urandom), 8'($urandom), ($urandom_range(7) == 0));
      drain_pipe();
    end
    stall_free = 1'b0;
  endtask

  initial begin
    fail_count   = 0;
    cycle_count  = 0;
    stall_free   = 1'b0;
    gray_en = 0; inv_en = 0; pastel_en = 0; crt_en = 0;
    hue_step = 0; darken = rpfc_pkg::DARKEN_RESET; hue_angle = 0;
    rst_n              = 1'b0;
    pix_ch.valid       = 1'b0;
    pix_ch.pixel_word  = '0;
    pix_ch.line_number = '0;
    pix_ch.noise       = '0;
    pix_ch.frame_end   = 1'b0;
    reg_ch.valid       = 1'b0;
    reg_ch.index       = '0;
    reg_ch.data        = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_widening();
    test_stages();
    test_random_frames();
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
